[src/mac_pkg.sv]
// Package for the MAC address text parser.
// Holds the shared types, character codes and the character decode functions.
// No dependencies.
package mac_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned OctetWidth = 8;
    localparam int unsigned NumOctets  = 6;
    localparam int unsigned MacWidth   = OctetWidth * NumOctets;
    localparam int unsigned CountWidth = 3;

    localparam logic [CountWidth-1:0] LastColon = CountWidth'(5);

    localparam logic [CharWidth-1:0] CharNul    = 8'h00;
    localparam logic [CharWidth-1:0] CharColon  = 8'h3a;
    localparam logic [CharWidth-1:0] CharZero   = 8'h30;
    localparam logic [CharWidth-1:0] CharNine   = 8'h39;
    localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
    localparam logic [CharWidth-1:0] CharLowerF = 8'h66;
    localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
    localparam logic [CharWidth-1:0] CharUpperF = 8'h46;

    typedef enum logic [1:0] {
        CLASS_TERM,
        CLASS_HEX,
        CLASS_COLON,
        CLASS_OTHER
    } char_class_t;

    // Character held in the input register, handed to the parse core.
    typedef struct packed {
        logic                 valid;
        logic [CharWidth-1:0] character;
    } mac_stage_t;

    function automatic char_class_t classify(input logic [CharWidth-1:0] c);
        char_class_t cls;
        cls = CLASS_OTHER;
        if (c == CharNul)
        begin
            cls = CLASS_TERM;
        end
        else if (c == CharColon)
        begin
            cls = CLASS_COLON;
        end
        else if ((c >= CharZero && c <= CharNine) ||
                 (c >= CharLowerA && c <= CharLowerF) ||
                 (c >= CharUpperA && c <= CharUpperF))
        begin
            cls = CLASS_HEX;
        end
        return cls;
    endfunction

    // Digit value of a hex character; meaningless for anything else.
    function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
        logic [3:0] v;
        v = c[3:0];
        if (c >= CharZero && c <= CharNine)
        begin
            v = c[3:0];
        end
        else
        begin
            // 'a'..'f' and 'A'..'F' have low nibble 1..6
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

[src/mac_if.sv]
// Valid/ready channel interfaces for the MAC address text parser.
// Depends on mac_pkg for field widths.
interface mac_char_if;
    import mac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface mac_result_if;
    import mac_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [MacWidth-1:0] mac_value;

    modport source (output valid, output ok, output mac_value, input ready);
    modport sink (input valid, input ok, input mac_value, output ready);
endinterface

[src/mac_char_reg.sv]
// Input register of the MAC address text parser.
// Depends on mac_pkg and mac_char_if.
module mac_char_reg (
    input  logic               clk,
    input  logic               rst_n,
    mac_char_if.sink           char_in,
    input  logic               take,
    output mac_pkg::mac_stage_t stage
);
    import mac_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [CharWidth-1:0] char_reg;

    // Refill when the register is empty or the held character moves on this cycle.
    assign char_in.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (char_in.ready)
        begin
            valid_next = char_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            char_reg <= char_in.character;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.character = char_reg;

endmodule

[src/mac_parse_core.sv]
// Parse state and result register of the MAC address text parser.
// Depends on mac_pkg and mac_result_if.
module mac_parse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  mac_pkg::mac_stage_t stage,
    output logic               take,
    mac_result_if.source       result_out
);
    import mac_pkg::*;

    logic [OctetWidth-1:0] octet_reg [NumOctets];
    logic [OctetWidth-1:0] group_reg;
    logic [OctetWidth-1:0] group_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  failed_reg;
    logic                  failed_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  ok_reg;
    logic [MacWidth-1:0]   mac_reg;

    char_class_t           cls;
    logic [3:0]            digit;
    logic                  slot_free;
    logic                  store_en;
    logic [CountWidth-1:0] store_idx;
    logic                  emit;
    logic                  ok_now;
    logic [MacWidth-1:0]   mac_now;

    assign cls       = classify(stage.character);
    assign digit     = hex_value(stage.character);
    assign slot_free = !out_valid_reg || result_out.ready;

    // Only a terminator needs room in the result register.
    assign take = stage.valid && ((cls != CLASS_TERM) || slot_free);
    assign emit = take && (cls == CLASS_TERM);

    assign ok_now = !failed_reg && (count_reg == LastColon);

    always_comb
    begin
        for (int i = 0; i < NumOctets; i++)
        begin
            mac_now[i*OctetWidth +: OctetWidth] = octet_reg[i];
        end
        if (ok_now)
        begin
            mac_now[LastColon*OctetWidth +: OctetWidth] = group_reg;
        end
    end

    always_comb
    begin
        group_next  = group_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        store_en    = 1'b0;
        store_idx   = count_reg;
        if (take)
        begin
            if (cls == CLASS_TERM)
            begin
                group_next  = '0;
                count_next  = '0;
                failed_next = 1'b0;
                store_en    = ok_now;
                store_idx   = LastColon;
            end
            else if (!failed_reg)
            begin
                unique case (cls)
                    CLASS_HEX:
                    begin
                        // Shifting in a digit overflows once the high nibble is set.
                        if (group_reg[7:4] != 4'd0)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            group_next = {group_reg[3:0], digit};
                        end
                    end
                    CLASS_COLON:
                    begin
                        if (count_reg >= LastColon)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            store_en   = 1'b1;
                            count_next = CountWidth'(count_reg + 1'b1);
                            group_next = '0;
                        end
                    end
                    CLASS_OTHER:
                    begin
                        failed_next = 1'b1;
                    end
                    CLASS_TERM:
                    begin
                        failed_next = failed_reg;
                    end
                    default:
                    begin
                        failed_next = failed_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg     <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NumOctets; i++)
            begin
                octet_reg[i] <= '0;
            end
        end
        else
        begin
            group_reg     <= group_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
            if (store_en)
            begin
                octet_reg[store_idx] <= group_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ok_reg  <= ok_now;
            mac_reg <= mac_now;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.ok        = ok_reg;
    assign result_out.mac_value = mac_reg;

endmodule

[src/mac_address_text_parser.sv]
// MAC address text parser: one character per cycle, one result per terminator.
// A terminator waits in the input register until the result register has room; its
// result is then written to the result register, from which it transfers.
// Throughput: one character per cycle; only a terminator waits, and only while
// the result register still holds an untaken result.
// Reset clears the octet store, group, colon count, error flag and both valids.
// Depends on mac_pkg, mac_if, mac_char_reg and mac_parse_core.
module mac_address_text_parser (
    input  logic         clk,
    input  logic         rst_n,
    mac_char_if.sink     char_in,
    mac_result_if.source result_out
);
    import mac_pkg::*;

    mac_stage_t stage;
    logic       take;

    mac_char_reg u_char_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .take    (take),
        .stage   (stage)
    );

    mac_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .take       (take),
        .result_out (result_out)
    );

endmodule

[sim/mac_parser_checker.sv]
`timescale 1ns / 1ps
// Checker for the MAC address text parser: predicts one result per terminator.
// Watches the character and result channels and compares each result transfer.
// Depends on mac_pkg and mac_if.
module mac_parser_checker
    import mac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mac_char_if   char_mon,
    mac_result_if result_mon,
    output int    mismatches,
    output int    outstanding
);

    localparam int unsigned MaxOctet = 255;

    typedef struct packed {
        logic                ok;
        logic [MacWidth-1:0] mac_value;
    } mac_result_t;

    logic [OctetWidth-1:0] octets [NumOctets];
    logic [OctetWidth-1:0] group_acc;
    logic [CountWidth-1:0] colons_seen;
    logic                  parse_error;
    mac_result_t           expected_q [$];
    int                    mismatch_count = 0;
    int                    pending_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic absorb_char(input logic [CharWidth-1:0] c);
        mac_result_t res;
        char_class_t kind;
        logic [3:0]  nib;
        logic [11:0] acc;
        nib  = '0;
        kind = CLASS_OTHER;
        if (c == CharNul)
        begin
            kind = CLASS_TERM;
        end
        else if (c == CharColon)
        begin
            kind = CLASS_COLON;
        end
        else if (c >= CharZero && c <= CharNine)
        begin
            kind = CLASS_HEX;
            nib  = 4'(c - CharZero);
        end
        else if (c >= CharLowerA && c <= CharLowerF)
        begin
            kind = CLASS_HEX;
            nib  = 4'(c - CharLowerA + 8'd10);
        end
        else if (c >= CharUpperA && c <= CharUpperF)
        begin
            kind = CLASS_HEX;
            nib  = 4'(c - CharUpperA + 8'd10);
        end

        if (kind == CLASS_TERM)
        begin
            res.ok = !parse_error && colons_seen == LastColon;
            if (res.ok)
            begin
                octets[NumOctets-1] = group_acc;
            end
            for (int i = 0; i < NumOctets; i++)
            begin
                res.mac_value[OctetWidth*i +: OctetWidth] = octets[i];
            end
            expected_q.push_back(res);
            group_acc   = '0;
            colons_seen = '0;
            parse_error = 1'b0;
        end
        else if (!parse_error)
        begin
            case (kind)
                CLASS_HEX:
                begin
                    acc = {group_acc, 4'b0000} + 12'(nib);
                    // an overflowing digit leaves the group as it was
                    if (acc > 12'(MaxOctet))
                    begin
                        parse_error = 1'b1;
                    end
                    else
                    begin
                        group_acc = acc[OctetWidth-1:0];
                    end
                end
                CLASS_COLON:
                begin
                    if (colons_seen >= LastColon)
                    begin
                        parse_error = 1'b1;
                    end
                    else
                    begin
                        octets[colons_seen] = group_acc;
                        colons_seen         = colons_seen + 1'b1;
                        group_acc           = '0;
                    end
                end
                default:
                begin
                    parse_error = 1'b1;
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mac_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NumOctets; i++)
            begin
                octets[i] = '0;
            end
            group_acc   = '0;
            colons_seen = '0;
            parse_error = 1'b0;
            expected_q.delete();
        end
        else
        begin
            if (char_mon.valid && char_mon.ready)
            begin
                absorb_char(char_mon.character);
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no result expected: ok %0b mac_value %h",
                           result_mon.ok, result_mon.mac_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result_mon.ok !== want.ok)
                    begin
                        $error("ok mismatch: expected %0b, actual %0b",
                               want.ok, result_mon.ok);
                        mismatch_count++;
                    end
                    if (result_mon.mac_value !== want.mac_value)
                    begin
                        $error("mac_value mismatch: expected %h, actual %h",
                               want.mac_value, result_mon.mac_value);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_q.size();
    end

endmodule

[sim/tb_mac_address_text_parser.sv]
`timescale 1ns / 1ps
// Testbench top for the MAC address text parser: drives address text and stalls results.
// Depends on mac_pkg, mac_if, mac_address_text_parser and mac_parser_checker.
module tb_mac_address_text_parser;
    import mac_pkg::*;

    localparam int RandomChars = 1400;
    localparam int LongHold    = 300;
    localparam int DrainCycles = 8;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef enum logic [1:0] {
        MANGLE_REPLACE,
        MANGLE_EXTRA_COLON,
        MANGLE_DROP,
        MANGLE_TRAILER
    } mangle_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   burst_left;
    int   chars_sent;
    bit   hold_request;

    mac_char_if   char_ch ();
    mac_result_if result_ch ();

    mac_address_text_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .result_out (result_ch)
    );

    mac_parser_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_mon    (char_ch),
        .result_mon  (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_char(input logic [CharWidth-1:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        char_ch.valid     <= 1'b1;
        char_ch.character <= c;
        do @(posedge clk); while (!char_ch.ready);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
        send_char(CharNul);
    endtask

    // Hold the sender until every predicted result has been taken.
    task automatic drain_results();
        char_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] v, input bit upper);
        logic [CharWidth-1:0] c;
        if (v < 4'd10)
        begin
            c = CharZero + 8'(v);
        end
        else if (upper)
        begin
            c = CharUpperA + 8'(v - 4'd10);
        end
        else
        begin
            c = CharLowerA + 8'(v - 4'd10);
        end
        return c;
    endfunction

    task automatic build_address(ref logic [CharWidth-1:0] text [$]);
        int      ndig;
        int      pos;
        mangle_t how;
        text.delete();
        for (int g = 0; g < NumOctets; g++)
        begin
            case ($urandom_range(0, 19))
                0:       ndig = 0;
                1, 2, 3: ndig = 1;
                4:       ndig = 3;
                default: ndig = 2;
            endcase
            for (int d = 0; d < ndig; d++)
            begin
                // three-digit groups mostly carry a leading zero and still fit
                if (ndig == 3 && d == 0 && $urandom_range(0, 2) != 0)
                begin
                    text.push_back(CharZero);
                end
                else
                begin
                    text.push_back(hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
                end
            end
            if (g < NumOctets - 1)
            begin
                text.push_back(CharColon);
            end
        end
        if ($urandom_range(0, 9) < 3)
        begin
            how = mangle_t'($urandom_range(0, 3));
            pos = $urandom_range(0, text.size());
            case (how)
                MANGLE_REPLACE:
                begin
                    if (pos < text.size())
                    begin
                        text[pos] = 8'($urandom_range(1, 255));
                    end
                end
                MANGLE_EXTRA_COLON:
                begin
                    text.insert(pos, CharColon);
                end
                MANGLE_DROP:
                begin
                    if (pos < text.size())
                    begin
                        text.delete(pos);
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
    endtask

    // Receiver: ready follows a pattern of its own, or holds off once on request.
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       phase;
        bit       hold_done;
        result_ch.ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_ALWAYS:   result_ch.ready <= 1'b1;
                    RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     result_ch.ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [CharWidth-1:0] text [$];
        int                   nstrings;
        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.character = '0;
        burst_left        = 0;
        chars_sent        = 0;
        hold_request      = 1'b0;
        nstrings          = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("9f::::F");
        send_text("fF:A::::1ab");
        send_text("::::::");
        send_text("g:");
        send_text("");
        drain_results();

        chars_sent = 0;
        while (chars_sent < RandomChars)
        begin
            if (nstrings == 10)
            begin
                hold_request = 1'b1;
            end
            if (nstrings == 30)
            begin
                drain_results();
            end
            if ($urandom_range(0, 9) < 7)
            begin
                build_address(text);
            end
            else
            begin
                text.delete();
                repeat ($urandom_range(0, 12)) text.push_back(8'($urandom_range(0, 255)));
            end
            foreach (text[i])
            begin
                send_char(text[i]);
            end
            send_char(CharNul);
            nstrings++;
        end

        drain_results();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("mac_address_text_parser regression: pass");
        end
        else
        begin
            $display("mac_address_text_parser regression: fail");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("mac_address_text_parser regression: fail");
        $finish;
    end

endmodule

[sim.f]
src/mac_pkg.sv
src/mac_if.sv
src/mac_char_reg.sv
src/mac_parse_core.sv
src/mac_address_text_parser.sv
sim/mac_parser_checker.sv
sim/tb_mac_address_text_parser.sv
